/* rtl/core/motor_plant_sim_step_core_macros.svh */
// Assertion macros used by the checker file of the motor plant core.
`ifndef MOTOR_PLANT_SIM_STEP_CORE_MACROS_SVH
`define MOTOR_PLANT_SIM_STEP_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPSS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MPSS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/mpss_pkg.sv */
// Types, constants and helper functions of the motor plant core.
package mpss_pkg;

	localparam int OP_W    = 33;
	localparam int PROD_W  = 2 * OP_W;
	localparam int SCORE_W = 48;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DRIVE_GAIN    = 3'd0,
		CFG_INV_TOP_SPEED = 3'd1,
		CFG_STATIC_LIMIT  = 3'd2,
		CFG_KINETIC_DECEL = 3'd3,
		CFG_GOAL_POSITION = 3'd4,
		CFG_SETTLE_BAND   = 3'd5,
		CFG_TIMEOUT_TICKS = 3'd6,
		CFG_SETTLE_TICKS  = 3'd7
	} cfg_idx_t;

	localparam logic [30:0] DRIVE_GAIN_RST    = 31'd65536;
	localparam logic [30:0] INV_TOP_SPEED_RST = 31'd65536;
	localparam logic [23:0] TIMEOUT_TICKS_RST = 24'd1000;

	localparam logic signed [PROD_W-1:0] S32_MAX    = 66'sd2147483647;
	localparam logic signed [PROD_W-1:0] S32_MIN    = -66'sd2147483648;
	localparam logic signed [PROD_W-1:0] FACTOR_ONE = 66'sd65536;

	typedef struct packed {
		logic signed [31:0] drive_voltage;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0]  position;
		logic signed [31:0]  velocity;
		logic [SCORE_W-1:0]  error_score;
		logic                settled;
		logic                done_res;
	} out_beat_t;

	// Saturate a wide signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
		logic signed [31:0] r;
		if (x > S32_MAX) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < S32_MIN) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

/* rtl/core/mpss_chan_if.sv */
// Valid/ready channel carrying one beat of a packed payload type.
interface mpss_chan_if #(
	parameter type beat_t = logic
);
	logic  valid;
	logic  ready;
	beat_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/mpss_mul.sv */
// Shared signed multiplier with a registered product.
module mpss_mul (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [mpss_pkg::OP_W-1:0]     a,
	input  logic signed [mpss_pkg::OP_W-1:0]     b,
	output logic signed [mpss_pkg::PROD_W-1:0]   prod
);

	logic signed [mpss_pkg::PROD_W-1:0] prod_q;

	// Hold the product until the sequencer issues the next operand pair.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	assign prod = prod_q;

endmodule

/* rtl/core/motor_plant_sim_step_core.sv */
// A live tick steps the sequencer from S_VI through S_ACC and then loads its result in S_FIN;
// a tick after the run has ended (or with nothing left to run) goes straight to S_FIN.
// No new input beat is taken until the sequencer is back in S_IDLE. The seven products
// of a live tick all go through the single 33x33 multiplier. A stalled result holds
// the sequencer in its last state until the output slot frees.
// Reset (arst_n low, asynchronous): config returns to its defaults, the plant state
// and run flag clear, and the output slot empties.
module motor_plant_sim_step_core #(
	parameter logic [31:0] DT_Q32    = 32'd4294967,
	parameter int          TICK_BITS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	mpss_chan_if.sink                          tick_in,
	mpss_chan_if.source                        tick_out,
	input  logic                               cfg_we,
	input  logic [mpss_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [mpss_pkg::CFG_W-1:0]         cfg_wdata
);

	// Counter compares run at the wider of the tick counter and the 24-bit limits.
	localparam int CNT_W = (TICK_BITS > 24) ? TICK_BITS : 24;
	localparam int OP_W  = mpss_pkg::OP_W;
	localparam int PW    = mpss_pkg::PROD_W;

	// One-hot sequencer: each state names the product it issues or the update it makes.
	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_VI   = 13'b0000000000010, // issue vel * inv_top_speed
		S_GD   = 13'b0000000000100, // form factor, issue gain * drive
		S_PV   = 13'b0000000001000, // form torque, issue vel * dt
		S_TF   = 13'b0000000010000, // keep position step, issue torque * factor
		S_FR   = 13'b0000000100000, // saturate and apply friction
		S_AD   = 13'b0000001000000, // issue acc * dt
		S_DD   = 13'b0000010000000, // keep dv, issue dv * dt
		S_UPD  = 13'b0000100000000, // integrate position and velocity
		S_ERR  = 13'b0001000000000, // absolute error and settle count
		S_SC   = 13'b0010000000000, // issue |err| * dt
		S_ACC  = 13'b0100000000000, // score, tick count, end-of-run rule
		S_FIN  = 13'b1000000000000  // load the output slot
	} seq_state_t;

	seq_state_t state_q;

	// Configuration registers.
	logic [30:0]        gain_q;
	logic [30:0]        inv_q;
	logic [30:0]        static_q;
	logic [30:0]        kinetic_q;
	logic signed [31:0] goal_q;
	logic [30:0]        band_q;
	logic [23:0]        timeout_q;
	logic [23:0]        settle_need_q;

	// Plant state.
	logic signed [31:0]              pos_q;
	logic signed [31:0]              vel_q;
	logic [TICK_BITS-1:0]            settle_q;
	logic [TICK_BITS-1:0]            tick_q;
	logic [mpss_pkg::SCORE_W-1:0]    score_q;
	logic                            run_over_q;

	// Working registers of one tick.
	logic signed [31:0] drive_q;
	logic signed [31:0] factor_q;
	logic signed [31:0] torque_q;
	logic signed [31:0] pv_q;
	logic signed [31:0] acc_q;
	logic signed [31:0] dv_q;
	logic [31:0]        aerr_q;

	// Output slot.
	mpss_pkg::out_beat_t out_q;
	logic                out_valid_q;

	// Shared multiplier.
	logic                 mul_en;
	logic signed [OP_W-1:0] mul_a;
	logic signed [OP_W-1:0] mul_b;
	logic signed [PW-1:0]   prod;

	logic in_fire;
	logic out_load;

	// Combinational helpers.
	logic signed [PW-1:0] factor_wide;
	logic signed [31:0]   acc_raw;
	logic signed [31:0]   acc_fr;
	logic signed [32:0]   acc_mag;
	logic signed [32:0]   acc_kin;
	logic signed [31:0]   pdv;
	logic signed [33:0]   pos_sum;
	logic signed [32:0]   vel_sum;
	logic signed [32:0]   err;
	logic [32:0]          err_abs;
	logic [31:0]          score_inc;
	logic [mpss_pkg::SCORE_W:0] score_sum;
	logic [TICK_BITS-1:0] tick_nxt;
	logic [TICK_BITS-1:0] settle_inc;
	logic                 live_now;
	logic                 live_after;

	function automatic logic keep_running(
		input logic [TICK_BITS-1:0] tick,
		input logic [TICK_BITS-1:0] settle,
		input logic [23:0]          timeout,
		input logic [23:0]          need
	);
		return (CNT_W'(tick) < CNT_W'(timeout)) ||
		       ((settle != '0) && (CNT_W'(settle) < CNT_W'(need)));
	endfunction

	assign in_fire  = tick_in.valid && tick_in.ready;
	assign out_load = (state_q == S_FIN) && (!out_valid_q || tick_out.ready);

	assign tick_in.ready  = (state_q == S_IDLE);
	assign tick_out.valid = out_valid_q;
	assign tick_out.data  = out_q;

	mpss_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Operand select for the shared multiplier.
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			S_VI: begin
				mul_a = OP_W'(vel_q);
				mul_b = OP_W'(inv_q);
			end
			S_GD: begin
				mul_a = OP_W'(gain_q);
				mul_b = OP_W'(drive_q);
			end
			S_PV: begin
				mul_a = OP_W'(vel_q);
				mul_b = OP_W'(DT_Q32);
			end
			S_TF: begin
				mul_a = OP_W'(torque_q);
				mul_b = OP_W'(factor_q);
			end
			S_AD: begin
				mul_a = OP_W'(acc_q);
				mul_b = OP_W'(DT_Q32);
			end
			S_DD: begin
				// dv is a plain slice of the product, so feed it straight back.
				mul_a = OP_W'($signed(prod[63:32]));
				mul_b = OP_W'(DT_Q32);
			end
			S_SC: begin
				mul_a = OP_W'(aerr_q);
				mul_b = OP_W'(DT_Q32);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// Arithmetic around the product register.
	always_comb begin
		factor_wide = mpss_pkg::FACTOR_ONE - (prod >>> 16);
		acc_raw     = mpss_pkg::sat32(prod >>> 16);

		// Static friction at rest, kinetic friction pulling toward zero in motion.
		acc_mag = acc_raw[31] ? -33'(acc_raw) : 33'(acc_raw);
		acc_kin = '0;
		acc_fr  = acc_raw;
		if (vel_q == '0) begin
			if (acc_mag < $signed({2'b00, static_q})) begin
				acc_fr = '0;
			end
		end else if (acc_raw > 0) begin
			acc_kin = 33'(acc_raw) - $signed({2'b00, kinetic_q});
			acc_fr  = acc_kin[32] ? 32'sd0 : acc_kin[31:0];
		end else if (acc_raw < 0) begin
			acc_kin = 33'(acc_raw) + $signed({2'b00, kinetic_q});
			acc_fr  = (acc_kin > 0) ? 32'sd0 : acc_kin[31:0];
		end

		// Position uses the old velocity plus half the velocity step.
		pdv     = prod[64:33];
		pos_sum = 34'(pos_q) + 34'(pv_q) + 34'(pdv);
		vel_sum = 33'(vel_q) + 33'(dv_q);

		err     = 33'(goal_q) - 33'(pos_q);
		err_abs = err[32] ? 33'(-err) : 33'(err);

		score_inc = prod[63:32];
		score_sum = {1'b0, score_q} + (mpss_pkg::SCORE_W + 1)'(score_inc);

		tick_nxt   = (tick_q == '1) ? tick_q : tick_q + TICK_BITS'(1);
		settle_inc = (settle_q == '1) ? settle_q : settle_q + TICK_BITS'(1);

		live_now   = keep_running(tick_q, settle_q, timeout_q, settle_need_q);
		live_after = keep_running(tick_nxt, settle_q, timeout_q, settle_need_q);
	end

	// Sequencer, plant state, configuration and output slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			gain_q        <= mpss_pkg::DRIVE_GAIN_RST;
			inv_q         <= mpss_pkg::INV_TOP_SPEED_RST;
			static_q      <= '0;
			kinetic_q     <= '0;
			goal_q        <= '0;
			band_q        <= '0;
			timeout_q     <= mpss_pkg::TIMEOUT_TICKS_RST;
			settle_need_q <= '0;
			pos_q         <= '0;
			vel_q         <= '0;
			settle_q      <= '0;
			tick_q        <= '0;
			score_q       <= '0;
			run_over_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (mpss_pkg::cfg_idx_t'(cfg_idx))
					mpss_pkg::CFG_DRIVE_GAIN:    gain_q        <= cfg_wdata[30:0];
					mpss_pkg::CFG_INV_TOP_SPEED: inv_q         <= cfg_wdata[30:0];
					mpss_pkg::CFG_STATIC_LIMIT:  static_q      <= cfg_wdata[30:0];
					mpss_pkg::CFG_KINETIC_DECEL: kinetic_q     <= cfg_wdata[30:0];
					mpss_pkg::CFG_GOAL_POSITION: goal_q        <= cfg_wdata;
					mpss_pkg::CFG_SETTLE_BAND:   band_q        <= cfg_wdata[30:0];
					mpss_pkg::CFG_TIMEOUT_TICKS: timeout_q     <= cfg_wdata[23:0];
					mpss_pkg::CFG_SETTLE_TICKS:  settle_need_q <= cfg_wdata[23:0];
					default: ;
				endcase
			end

			// Drop the beat once taken; a fresh load keeps the slot full.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (tick_out.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (run_over_q) begin
							state_q <= S_FIN;
						end else if (!live_now) begin
							run_over_q <= 1'b1;
							state_q    <= S_FIN;
						end else begin
							state_q <= S_VI;
						end
					end
				end
				S_VI:  state_q <= S_GD;
				S_GD:  state_q <= S_PV;
				S_PV:  state_q <= S_TF;
				S_TF:  state_q <= S_FR;
				S_FR:  state_q <= S_AD;
				S_AD:  state_q <= S_DD;
				S_DD:  state_q <= S_UPD;
				S_UPD: begin
					pos_q   <= mpss_pkg::sat32(PW'(pos_sum));
					vel_q   <= mpss_pkg::sat32(PW'(vel_sum));
					state_q <= S_ERR;
				end
				S_ERR: begin
					if (err_abs < {2'b00, band_q}) begin
						settle_q <= settle_inc;
					end else begin
						settle_q <= '0;
					end
					state_q <= S_SC;
				end
				S_SC:  state_q <= S_ACC;
				S_ACC: begin
					score_q    <= score_sum[mpss_pkg::SCORE_W] ? '1 :
					              score_sum[mpss_pkg::SCORE_W-1:0];
					tick_q     <= tick_nxt;
					run_over_q <= !live_after;
					state_q    <= S_FIN;
				end
				S_FIN: begin
					// Hold here while the previous result still waits.
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers and output payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			drive_q <= tick_in.data.drive_voltage;
		end
		if (state_q == S_GD) begin
			factor_q <= mpss_pkg::sat32(factor_wide);
		end
		if (state_q == S_PV) begin
			torque_q <= mpss_pkg::sat32(prod >>> 16);
		end
		if (state_q == S_TF) begin
			pv_q <= prod[63:32];
		end
		if (state_q == S_FR) begin
			acc_q <= acc_fr;
		end
		if (state_q == S_DD) begin
			dv_q <= prod[63:32];
		end
		if (state_q == S_ERR) begin
			aerr_q <= err_abs[31:0];
		end
		if (out_load) begin
			out_q.position    <= pos_q;
			out_q.velocity    <= vel_q;
			out_q.error_score <= score_q;
			out_q.settled     <= (settle_q != '0);
			out_q.done_res    <= run_over_q;
		end
	end

endmodule

/* rtl/core/mpss_checker.sv */
// Port-level checks of the motor plant core, bound to its top level.
`include "motor_plant_sim_step_core_macros.svh"

module mpss_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] out_position,
	input logic signed [31:0] out_velocity,
	input logic               out_done
);

	logic               in_fire;
	logic               out_fire;
	logic [1:0]         pend_q;
	logic               done_seen_q;
	logic signed [31:0] last_pos_q;
	logic signed [31:0] last_vel_q;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// Track beats taken but not yet delivered, and the frozen state once a run ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			done_seen_q <= 1'b0;
		end else begin
			pend_q <= pend_q + 2'(in_fire) - 2'(out_fire);
			if (out_fire && out_done) begin
				done_seen_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire && out_done) begin
			last_pos_q <= out_position;
			last_vel_q <= out_velocity;
		end
	end

	`MPSS_ASSERT_NXT(a_busy_after_take, clk, arst_n, in_fire, !in_ready, "ready after a taken beat")
	`MPSS_ASSERT_IMP(a_no_extra_result, clk, arst_n, out_valid, pend_q != 2'd0, "result without a tick")
	`MPSS_ASSERT_IMP(a_done_sticky, clk, arst_n, out_valid && done_seen_q, out_done, "run restarted")
	`MPSS_ASSERT_IMP(a_state_frozen, clk, arst_n, out_valid && done_seen_q, (out_position == last_pos_q) && (out_velocity == last_vel_q), "state moved after run end")

endmodule

bind motor_plant_sim_step_core mpss_checker u_mpss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (tick_in.valid),
	.in_ready     (tick_in.ready),
	.out_valid    (tick_out.valid),
	.out_ready    (tick_out.ready),
	.out_position (tick_out.data.position),
	.out_velocity (tick_out.data.velocity),
	.out_done     (tick_out.data.done_res)
);

/* tb/testbench.sv */
// Self-checking testbench for the motor plant simulation step core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Plant tick length in Q0.32 seconds; must match the DUT parameter default.
	localparam longint DT_TICK   = 64'sd4294967;
	localparam longint Q_MAX     = 64'sd2147483647;
	localparam longint Q_MIN     = -64'sd2147483648;
	localparam longint SCORE_TOP = 64'sh0000_FFFF_FFFF_FFFF;
	localparam int     ITEM_GOAL = 400;

	// Receiver stall styles; each holds for a random stretch of cycles.
	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKED, RX_BUSY} rx_style_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [mpss_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [mpss_pkg::CFG_W-1:0]     cfg_wdata;

	mpss_chan_if #(.beat_t(mpss_pkg::in_beat_t))  tick_in_if ();
	mpss_chan_if #(.beat_t(mpss_pkg::out_beat_t)) tick_out_if ();

	motor_plant_sim_step_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_in   (tick_in_if),
		.tick_out  (tick_out_if),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Plant configuration as the DUT should hold it (reset values).
	logic [30:0]        gain_q16      = 31'd65536;
	logic [30:0]        inv_speed_q16 = 31'd65536;
	logic [30:0]        stiction_q16  = 31'd0;
	logic [30:0]        coulomb_q16   = 31'd0;
	logic signed [31:0] goal_q16      = 32'sd0;
	logic [30:0]        band_q16      = 31'd0;
	logic [23:0]        timeout_lim   = 24'd1000;
	logic [23:0]        settle_goal   = 24'd0;

	// Plant state mirror.
	logic signed [31:0] pos_q      = 32'sd0;
	logic signed [31:0] vel_q      = 32'sd0;
	logic [23:0]        settle_run = 24'd0;
	logic [23:0]        ticks_done = 24'd0;
	logic [47:0]        score_q    = 48'd0;
	logic               halted     = 1'b0;

	mpss_pkg::in_beat_t  voltage_q[$];         // drive voltages waiting for the sender
	mpss_pkg::out_beat_t predicted_states[$];  // plant states owed by the DUT, oldest first

	int unsigned mismatch_count = 0;
	int unsigned result_idx     = 0;

	int unsigned         burst_left = 0;
	int unsigned         gap_left   = 0;
	int unsigned         rx_left    = 0;
	rx_style_t           rx_style   = RX_OPEN;
	mpss_pkg::out_beat_t seen_state;
	mpss_pkg::out_beat_t want_state;

	// ------------------------------------------------------------------
	// Plant predictor
	// ------------------------------------------------------------------

	function automatic longint clip32(longint x);
		if (x > Q_MAX)
			return Q_MAX;
		if (x < Q_MIN)
			return Q_MIN;
		return x;
	endfunction

	function automatic logic [23:0] bump24(logic [23:0] c);
		return (c == 24'hFF_FFFF) ? c : c + 24'd1;
	endfunction

	// Run goes on while short of the timeout, or while a settled stretch is
	// still shorter than the required settle length.
	function automatic bit plant_live();
		return (ticks_done < timeout_lim) ||
			(settle_run != 24'd0 && settle_run < settle_goal);
	endfunction

	// One live tick: force, friction, integration, settle count and score.
	function automatic void integrate_tick(logic signed [31:0] drive);
		longint torque;
		longint factor;
		longint acc;
		longint mag;
		longint dv;
		longint dp;
		longint err;
		longint inc;
		longint sum;
		torque = clip32((longint'(gain_q16) * longint'(drive)) >>> 16);
		factor = clip32(64'sd65536 - ((longint'(vel_q) * longint'(inv_speed_q16)) >>> 16));
		acc    = clip32((torque * factor) >>> 16);

		if (vel_q == 32'sd0) begin
			// at rest: stiction swallows anything weaker than the limit
			mag = (acc < 0) ? -acc : acc;
			if (mag < longint'(stiction_q16))
				acc = 0;
		end else if (acc > 0) begin
			// moving: Coulomb friction pulls toward zero and stops there
			acc = acc - longint'(coulomb_q16);
			if (acc < 0)
				acc = 0;
		end else if (acc < 0) begin
			acc = acc + longint'(coulomb_q16);
			if (acc > 0)
				acc = 0;
		end

		dv = (acc * DT_TICK) >>> 32;
		dp = ((longint'(vel_q) * DT_TICK) >>> 32) + ((dv * DT_TICK) >>> 33);
		pos_q = 32'(clip32(longint'(pos_q) + dp));
		vel_q = 32'(clip32(longint'(vel_q) + dv));

		err = longint'(goal_q16) - longint'(pos_q);
		if (err < 0)
			err = -err;
		settle_run = (err < longint'(band_q16)) ? bump24(settle_run) : 24'd0;

		inc = (err * DT_TICK) >>> 32;
		sum = longint'(score_q) + inc;
		score_q = (sum > SCORE_TOP) ? SCORE_TOP[47:0] : sum[47:0];

		ticks_done = bump24(ticks_done);
	endfunction

	// Apply one accepted beat to the mirror and return the state it must show.
	function automatic mpss_pkg::out_beat_t advance_plant(logic signed [31:0] drive);
		mpss_pkg::out_beat_t r;
		if (!halted) begin
			if (!plant_live()) begin
				halted = 1'b1;
			end else begin
				integrate_tick(drive);
				if (!plant_live())
					halted = 1'b1;
			end
		end
		r.position    = pos_q;
		r.velocity    = vel_q;
		r.error_score = score_q;
		r.settled     = (settle_run != 24'd0);
		r.done_res    = halted;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic flag_mismatch(string what, longint got, longint want);
		mismatch_count++;
		// keep the log bounded when the DUT is badly off
		if (mismatch_count <= 50)
			$display("[%0t] result %0d: %s got 0x%0h want 0x%0h",
				$realtime, result_idx, what, got, want);
	endtask

	// ------------------------------------------------------------------
	// Sender: bursts of beats with random gaps, fed from voltage_q
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_in_if.valid <= 1'b0;
			tick_in_if.data  <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			// predict at the edge where the beat is taken
			if (tick_in_if.valid && tick_in_if.ready)
				predicted_states.push_back(advance_plant(tick_in_if.data.drive_voltage));

			if (!tick_in_if.valid || tick_in_if.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					tick_in_if.valid <= 1'b0;
				end else if (voltage_q.size() != 0) begin
					tick_in_if.valid <= 1'b1;
					tick_in_if.data  <= voltage_q.pop_front();
					if (burst_left <= 1) begin
						// new burst; about a quarter run back to back with no gap
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
					end else begin
						burst_left--;
					end
				end else begin
					tick_in_if.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stall pattern plus field-by-field compare
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_out_if.ready <= 1'b0;
			rx_left  = 0;
			rx_style = RX_OPEN;
		end else begin
			if (tick_out_if.valid && tick_out_if.ready) begin
				seen_state = tick_out_if.data;
				if (predicted_states.size() == 0) begin
					flag_mismatch("unexpected beat, position",
						longint'(seen_state.position), 64'sd0);
				end else begin
					want_state = predicted_states.pop_front();
					if (seen_state.position !== want_state.position)
						flag_mismatch("position", longint'(seen_state.position),
							longint'(want_state.position));
					if (seen_state.velocity !== want_state.velocity)
						flag_mismatch("velocity", longint'(seen_state.velocity),
							longint'(want_state.velocity));
					if (seen_state.error_score !== want_state.error_score)
						flag_mismatch("error_score", longint'(seen_state.error_score),
							longint'(want_state.error_score));
					if (seen_state.settled !== want_state.settled)
						flag_mismatch("settled", longint'(seen_state.settled),
							longint'(want_state.settled));
					if (seen_state.done_res !== want_state.done_res)
						flag_mismatch("done_res", longint'(seen_state.done_res),
							longint'(want_state.done_res));
				end
				result_idx++;
			end

			// switch stall style every so often
			if (rx_left == 0) begin
				rx_style = rx_style_t'($urandom_range(0, 3));
				rx_left  = $urandom_range(5, 60);
			end else begin
				rx_left--;
			end
			case (rx_style)
				RX_OPEN:   tick_out_if.ready <= 1'b1;
				RX_COIN:   tick_out_if.ready <= 1'($urandom_range(0, 1));
				RX_CHOKED: tick_out_if.ready <= ($urandom_range(0, 7) == 0);
				default:   tick_out_if.ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Write one register; also update the predictor's copy (block is idle).
	task automatic write_reg(mpss_pkg::cfg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		case (idx)
			mpss_pkg::CFG_DRIVE_GAIN:    gain_q16      = val[30:0];
			mpss_pkg::CFG_INV_TOP_SPEED: inv_speed_q16 = val[30:0];
			mpss_pkg::CFG_STATIC_LIMIT:  stiction_q16  = val[30:0];
			mpss_pkg::CFG_KINETIC_DECEL: coulomb_q16   = val[30:0];
			mpss_pkg::CFG_GOAL_POSITION: goal_q16      = val;
			mpss_pkg::CFG_SETTLE_BAND:   band_q16      = val[30:0];
			mpss_pkg::CFG_TIMEOUT_TICKS: timeout_lim   = val[23:0];
			default:                     settle_goal   = val[23:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until the sender is empty and every owed state has come back.
	task automatic wait_plant_idle();
		do
			@(negedge clk);
		while (voltage_q.size() != 0 || tick_in_if.valid || predicted_states.size() != 0);
	endtask

	task automatic push_volts(logic [31:0] v);
		voltage_q.push_back(mpss_pkg::in_beat_t'(v));
	endtask

	// Mostly realistic drive within +/-12 V, some raw 32-bit noise and rails.
	function automatic logic [31:0] pick_voltage();
		case ($urandom_range(0, 9))
			0:       return $urandom();
			1:       return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2:       return 32'h0000_0000;
			default: return 32'(int'($urandom_range(0, 1572864)) - 786432);
		endcase
	endfunction

	// Coefficient: mostly modest, sometimes zero, full-range or all ones.
	function automatic logic [31:0] pick_coeff(int unsigned typical_hi);
		case ($urandom_range(0, 7))
			0:       return 32'h0000_0000;
			1:       return $urandom();
			2:       return 32'hFFFF_FFFF;
			default: return {1'($urandom_range(0, 1)), 31'($urandom_range(0, typical_hi))};
		endcase
	endfunction

	// Fresh plant settings for a random phase; timeout kept far ahead.
	task automatic reshuffle_config();
		logic [31:0] goal;
		write_reg(mpss_pkg::CFG_DRIVE_GAIN,    pick_coeff(32'h0010_0000));
		write_reg(mpss_pkg::CFG_INV_TOP_SPEED, pick_coeff(32'h0002_0000));
		write_reg(mpss_pkg::CFG_STATIC_LIMIT,  pick_coeff(32'h0008_0000));
		write_reg(mpss_pkg::CFG_KINETIC_DECEL, pick_coeff(32'h0008_0000));
		// aim near the current position half the time so settling shows up
		if ($urandom_range(0, 1) != 0)
			goal = 32'(int'(pos_q) + int'($urandom_range(0, 262144)) - 131072);
		else
			goal = $urandom();
		write_reg(mpss_pkg::CFG_GOAL_POSITION, goal);
		write_reg(mpss_pkg::CFG_SETTLE_BAND,   pick_coeff(32'h0004_0000));
		write_reg(mpss_pkg::CFG_TIMEOUT_TICKS,
			{8'($urandom()), 24'($urandom_range(int'(ticks_done) + 700, 24'hFF_FFFF))});
		write_reg(mpss_pkg::CFG_SETTLE_TICKS,  $urandom());
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned fed;
		int unsigned n;
		bit          end_naturally;

		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_idx           = '0;
		cfg_wdata         = '0;
		tick_in_if.valid  = 1'b0;
		tick_in_if.data   = '0;
		tick_out_if.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Stiction at rest: below the limit stays put, at the limit moves.
		write_reg(mpss_pkg::CFG_STATIC_LIMIT, 32'h0002_0000);
		write_reg(mpss_pkg::CFG_TIMEOUT_TICKS, 32'h00FF_FFFF);
		@(negedge clk);
		push_volts(32'h0000_0000);
		push_volts(32'h0001_0000);
		push_volts(32'hFFFF_0000);
		push_volts(32'h0001_FFFF);
		push_volts(32'h0002_0000);
		wait_plant_idle();

		// Coulomb friction at its maximum clamps either direction to zero.
		write_reg(mpss_pkg::CFG_KINETIC_DECEL, 32'h7FFF_FFFF);
		write_reg(mpss_pkg::CFG_STATIC_LIMIT, 32'hFFFF_FFFF);
		@(negedge clk);
		push_volts(32'h7FFF_FFFF);
		push_volts(32'h8000_0000);
		push_volts(32'h0000_0000);
		wait_plant_idle();

		// Torque saturation: largest gain, no back-EMF.
		write_reg(mpss_pkg::CFG_KINETIC_DECEL, 32'h0000_0000);
		write_reg(mpss_pkg::CFG_DRIVE_GAIN, 32'hFFFF_FFFF);
		write_reg(mpss_pkg::CFG_INV_TOP_SPEED, 32'h0000_0000);
		@(negedge clk);
		push_volts(32'h7FFF_FFFF);
		push_volts(32'h8000_0000);
		push_volts(32'h0000_0001);
		push_volts(32'hFFFF_FFFF);
		wait_plant_idle();

		// Back-EMF factor saturation with the largest inverse speed.
		write_reg(mpss_pkg::CFG_INV_TOP_SPEED, 32'hFFFF_FFFF);
		@(negedge clk);
		push_volts(32'h7FFF_FFFF);
		push_volts(32'h8000_0000);
		push_volts(32'h0001_0000);
		wait_plant_idle();

		// Goal at both rails with the widest band, then right on the plant with a zero band.
		write_reg(mpss_pkg::CFG_DRIVE_GAIN, 32'h0000_0000);
		write_reg(mpss_pkg::CFG_GOAL_POSITION, 32'h7FFF_FFFF);
		write_reg(mpss_pkg::CFG_SETTLE_BAND, 32'h7FFF_FFFF);
		@(negedge clk);
		push_volts(32'h1234_5678);
		push_volts(32'hEDCB_A987);
		wait_plant_idle();
		write_reg(mpss_pkg::CFG_GOAL_POSITION, 32'h8000_0000);
		@(negedge clk);
		push_volts(32'h0000_0001);
		wait_plant_idle();
		write_reg(mpss_pkg::CFG_GOAL_POSITION, pos_q);
		write_reg(mpss_pkg::CFG_SETTLE_BAND, 32'h0000_0000);
		@(negedge clk);
		push_volts(32'h0000_0000);
		push_volts(32'h8000_0000);
		wait_plant_idle();

		// Random phases, each with its own settings, drained before the next.
		fed = 0;
		while (fed < ITEM_GOAL) begin
			n = $urandom_range(25, 70);
			reshuffle_config();
			@(negedge clk);
			repeat (n)
				push_volts(pick_voltage());
			fed += n;
			wait_plant_idle();
		end

		// Wind-down: timeout just ahead, a settled stretch keeps the run alive.
		end_naturally = 1'($urandom_range(0, 1));
		write_reg(mpss_pkg::CFG_SETTLE_BAND, 32'hFFFF_FFFF);
		write_reg(mpss_pkg::CFG_GOAL_POSITION, pos_q);
		write_reg(mpss_pkg::CFG_SETTLE_TICKS, 32'(settle_run) + 32'd6);
		write_reg(mpss_pkg::CFG_TIMEOUT_TICKS, 32'(ticks_done) + 32'd2);
		@(negedge clk);
		if (end_naturally) begin
			// run ends on the tick where the settled stretch is long enough
			repeat (30)
				push_volts(pick_voltage());
			wait_plant_idle();
		end else begin
			// still alive past the timeout, then drop the settle length so the
			// next beat finds nothing left to run
			repeat (4)
				push_volts(pick_voltage());
			wait_plant_idle();
			write_reg(mpss_pkg::CFG_SETTLE_TICKS, 32'h0000_0000);
			write_reg(mpss_pkg::CFG_TIMEOUT_TICKS, 32'h0000_0000);
			@(negedge clk);
			repeat (12)
				push_volts(pick_voltage());
			wait_plant_idle();
		end

		// Config writes after the end must not restart the run.
		write_reg(mpss_pkg::CFG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
		write_reg(mpss_pkg::CFG_DRIVE_GAIN, 32'h0001_0000);
		@(negedge clk);
		repeat (8)
			push_volts(pick_voltage());
		wait_plant_idle();

		// Let any stray beat surface before judging.
		repeat (30) @(posedge clk);
		if (predicted_states.size() != 0)
			flag_mismatch("states never delivered", longint'(predicted_states.size()), 64'sd0);

		if (mismatch_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule
